/* rtl/ahgs_pkg.sv */
package ahgs_pkg;

    localparam int CP_W = 21;

    localparam logic [CP_W-1:0] SYL_BASE   = 21'd44032;
    localparam logic [CP_W-1:0] SYL_END    = 21'd55204;
    localparam logic [CP_W-1:0] ALEF_BASE  = 21'h000627;
    localparam logic [CP_W-1:0] LEAD_JAMO  = 21'h001100;
    localparam logic [CP_W-1:0] VOWEL_JAMO = 21'h001161;
    localparam logic [CP_W-1:0] TAIL_JAMO  = 21'h0011A7;
    localparam logic [12:0]     ARABIC_ROW = 13'h0006;
    localparam logic [5:0]      FORM_ROM_SIZE = 6'd37;

    localparam logic [13:0] T28_MUL = 14'd9363;
    localparam logic [11:0] T21_MUL = 12'd3121;

    typedef struct packed {
        logic [CP_W-1:0] codepoint;
        logic            prior;
        logic            after;
        logic            done;
    } job_t;

    typedef enum logic [1:0] {
        SLOT_LEAD,
        SLOT_VOWEL,
        SLOT_TAIL
    } slot_t;

    function automatic logic [15:0] form_rom(input logic [5:0] idx);
        logic [15:0] base;
        case (idx)
            6'd0:    base = 16'hFE8D;
            6'd1:    base = 16'hFE8F;
            6'd2:    base = 16'hFE93;
            6'd3:    base = 16'hFE95;
            6'd4:    base = 16'hFE99;
            6'd5:    base = 16'hFE9D;
            6'd6:    base = 16'hFEA1;
            6'd7:    base = 16'hFEA5;
            6'd8:    base = 16'hFEA9;
            6'd9:    base = 16'hFEAB;
            6'd10:   base = 16'hFEAD;
            6'd11:   base = 16'hFEAF;
            6'd12:   base = 16'hFEB1;
            6'd13:   base = 16'hFEB5;
            6'd14:   base = 16'hFEB9;
            6'd15:   base = 16'hFEBD;
            6'd16:   base = 16'hFEC1;
            6'd17:   base = 16'hFEC5;
            6'd18:   base = 16'hFEC9;
            6'd19:   base = 16'hFECD;
            6'd26:   base = 16'hFED1;
            6'd27:   base = 16'hFED5;
            6'd28:   base = 16'hFED9;
            6'd29:   base = 16'hFEDD;
            6'd30:   base = 16'hFEE1;
            6'd31:   base = 16'hFEE5;
            6'd32:   base = 16'hFEE9;
            6'd33:   base = 16'hFEED;
            6'd34:   base = 16'hFEEF;
            6'd35:   base = 16'hFEF1;
            6'd36:   base = 16'hFE81;
            default: base = 16'h0000;
        endcase
        return base;
    endfunction

    function automatic logic is_arabic(input logic [CP_W-1:0] cp);
        return cp[CP_W-1:8] == ARABIC_ROW;
    endfunction

endpackage

/* rtl/ahgs_in_if.sv */
interface ahgs_in_if;
    import ahgs_pkg::*;

    logic            valid;
    logic            ready;
    logic [CP_W-1:0] codepoint;
    logic            string_end;

    modport source (output valid, output codepoint, output string_end, input ready);
    modport sink (input valid, input codepoint, input string_end, output ready);
endinterface

/* rtl/ahgs_out_if.sv */
interface ahgs_out_if;
    import ahgs_pkg::*;

    logic            valid;
    logic            ready;
    logic [CP_W-1:0] glyph;
    logic            char_last;
    logic            string_done;
    logic            bad_letter;

    modport source (
        output valid, output glyph, output char_last, output string_done,
        output bad_letter, input ready
    );
    modport sink (
        input valid, input glyph, input char_last, input string_done,
        input bad_letter, output ready
    );
endinterface

/* rtl/ahgs_front.sv */
module ahgs_front
    import ahgs_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    ahgs_in_if.sink       chars,
    input  logic          full,
    output logic          push,
    output job_t          push_job
);

    logic [CP_W-1:0] held_char_reg, held_char_next;
    logic            held_valid_reg, held_valid_next;
    logic            prev_arabic_reg, prev_arabic_next;
    logic            pend_valid_reg, pend_valid_next;
    job_t            pend_job_reg, pend_job_next;
    logic            accept;
    logic            cp_arabic;
    logic            held_arabic;

    assign chars.ready = !pend_valid_reg && !full;
    assign accept      = chars.valid && chars.ready;
    assign cp_arabic   = is_arabic(chars.codepoint);
    assign held_arabic = is_arabic(held_char_reg);

    always_comb
    begin
        held_char_next   = held_char_reg;
        held_valid_next  = held_valid_reg;
        prev_arabic_next = prev_arabic_reg;
        pend_valid_next  = pend_valid_reg;
        pend_job_next    = pend_job_reg;
        push             = 1'b0;
        push_job         = pend_job_reg;

        if (pend_valid_reg)
        begin
            if (!full)
            begin
                push            = 1'b1;
                pend_valid_next = 1'b0;
            end
        end
        else if (accept)
        begin
            if (held_valid_reg)
            begin
                push               = 1'b1;
                push_job.codepoint = held_char_reg;
                push_job.prior     = prev_arabic_reg;
                push_job.after     = cp_arabic;
                push_job.done      = 1'b0;
                if (chars.string_end)
                begin
                    pend_valid_next         = 1'b1;
                    pend_job_next.codepoint = chars.codepoint;
                    pend_job_next.prior     = held_arabic;
                    pend_job_next.after     = 1'b0;
                    pend_job_next.done      = 1'b1;
                    held_valid_next         = 1'b0;
                    held_char_next          = '0;
                    prev_arabic_next        = 1'b0;
                end
                else
                begin
                    held_char_next   = chars.codepoint;
                    prev_arabic_next = held_arabic;
                end
            end
            else if (chars.string_end)
            begin
                push               = 1'b1;
                push_job.codepoint = chars.codepoint;
                push_job.prior     = prev_arabic_reg;
                push_job.after     = 1'b0;
                push_job.done      = 1'b1;
                prev_arabic_next   = 1'b0;
            end
            else
            begin
                held_char_next  = chars.codepoint;
                held_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_char_reg   <= '0;
            held_valid_reg  <= 1'b0;
            prev_arabic_reg <= 1'b0;
            pend_valid_reg  <= 1'b0;
        end
        else
        begin
            held_char_reg   <= held_char_next;
            held_valid_reg  <= held_valid_next;
            prev_arabic_reg <= prev_arabic_next;
            pend_valid_reg  <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_job_reg <= pend_job_next;
    end

endmodule

/* rtl/ahgs_queue.sv */
module ahgs_queue
    import ahgs_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic q_valid,
    output job_t q_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = count_reg == FULL_CNT;
    assign q_valid = count_reg != '0;
    assign q_job   = mem[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

/* rtl/ahgs_back.sv */
module ahgs_back
    import ahgs_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  job_t          q_job,
    output logic          pop,
    ahgs_out_if.source    glyphs
);

    // classify and first reciprocal multiply
    logic            s1_valid_reg;
    logic            s1_hangul_reg;
    logic [13:0]     s1_s_reg;
    logic [8:0]      s1_t28_reg;
    logic [CP_W-1:0] s1_other_reg;
    logic            s1_bad_reg;
    logic            s1_done_reg;

    // jamo split, glyph sequencing
    logic            s2_valid_reg;
    logic            s2_hangul_reg;
    logic [8:0]      s2_t28_reg;
    logic [4:0]      s2_lead_reg;
    logic [4:0]      s2_tail_reg;
    logic [CP_W-1:0] s2_other_reg;
    logic            s2_bad_reg;
    logic            s2_done_reg;
    slot_t           slot_reg, slot_next;

    logic            out_valid_reg;
    logic [CP_W-1:0] out_glyph_reg;
    logic            out_last_reg;
    logic            out_done_reg;
    logic            out_bad_reg;

    logic            take;
    logic            s1_adv;
    logic            s2_free;
    logic            out_load;
    logic            emit;

    logic            c_hangul;
    logic [CP_W-1:0] c_s_full;
    logic [13:0]     c_s;
    logic [27:0]     c_t28_prod;
    logic            c_arabic;
    logic [CP_W-1:0] c_off_full;
    logic            c_in_rom;
    logic [15:0]     c_base;
    logic            c_bad;
    logic [15:0]     c_form;
    logic [CP_W-1:0] c_other;

    logic [20:0]     d_lead_prod;
    logic [13:0]     d_mul28;
    logic [13:0]     d_tail_full;

    logic [8:0]      e_lead21;
    logic [8:0]      e_vowel_full;
    logic            e_last;
    logic [CP_W-1:0] e_glyph;

    assign out_load = !out_valid_reg || glyphs.ready;
    assign emit     = s2_valid_reg && out_load;
    assign s2_free  = emit && e_last;
    assign s1_adv   = s1_valid_reg && (!s2_valid_reg || s2_free);
    assign take     = q_valid && (!s1_valid_reg || s1_adv);
    assign pop      = take;

    always_comb
    begin
        c_hangul   = (q_job.codepoint >= SYL_BASE) && (q_job.codepoint < SYL_END);
        c_s_full   = q_job.codepoint - SYL_BASE;
        c_s        = c_s_full[13:0];
        c_t28_prod = 28'(c_s) * 28'(T28_MUL);
        c_arabic   = is_arabic(q_job.codepoint);
        c_off_full = q_job.codepoint - ALEF_BASE;
        c_in_rom   = c_arabic && (q_job.codepoint >= ALEF_BASE)
                     && (c_off_full < CP_W'(FORM_ROM_SIZE));
        c_base     = form_rom(c_off_full[5:0]);
        c_bad      = c_arabic && (!c_in_rom || c_base == '0);
        c_form     = c_base + {14'd0, q_job.after, q_job.prior};
        c_other    = (c_arabic && !c_bad) ? CP_W'(c_form) : q_job.codepoint;
    end

    always_comb
    begin
        d_lead_prod = 21'(s1_t28_reg) * 21'(T21_MUL);
        d_mul28     = 14'({s1_t28_reg, 4'd0}) + 14'({s1_t28_reg, 3'd0})
                      + 14'({s1_t28_reg, 2'd0});
        d_tail_full = s1_s_reg - d_mul28;
    end

    always_comb
    begin
        e_lead21     = 9'({s2_lead_reg, 4'd0}) + 9'({s2_lead_reg, 2'd0})
                       + 9'(s2_lead_reg);
        e_vowel_full = s2_t28_reg - e_lead21;
        slot_next    = slot_reg;
        case (slot_reg)
            SLOT_LEAD:
            begin
                e_glyph   = LEAD_JAMO + CP_W'(s2_lead_reg);
                e_last    = !s2_hangul_reg;
                slot_next = SLOT_VOWEL;
            end
            SLOT_VOWEL:
            begin
                e_glyph   = VOWEL_JAMO + CP_W'(e_vowel_full[4:0]);
                e_last    = s2_tail_reg == '0;
                slot_next = SLOT_TAIL;
            end
            SLOT_TAIL:
            begin
                e_glyph   = TAIL_JAMO + CP_W'(s2_tail_reg);
                e_last    = 1'b1;
                slot_next = SLOT_LEAD;
            end
            default:
            begin
                e_glyph   = s2_other_reg;
                e_last    = 1'b1;
                slot_next = SLOT_LEAD;
            end
        endcase
        if (!s2_hangul_reg)
        begin
            e_glyph = s2_other_reg;
        end
        if (e_last)
        begin
            slot_next = SLOT_LEAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            slot_reg      <= SLOT_LEAD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_free)
            begin
                s2_valid_reg <= 1'b0;
            end
            if (emit)
            begin
                slot_reg <= slot_next;
            end
            if (out_load)
            begin
                out_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_hangul_reg <= c_hangul;
            s1_s_reg      <= c_s;
            s1_t28_reg    <= c_t28_prod[26:18];
            s1_other_reg  <= c_other;
            s1_bad_reg    <= c_bad;
            s1_done_reg   <= q_job.done;
        end
        if (s1_adv)
        begin
            s2_hangul_reg <= s1_hangul_reg;
            s2_t28_reg    <= s1_t28_reg;
            s2_lead_reg   <= d_lead_prod[20:16];
            s2_tail_reg   <= d_tail_full[4:0];
            s2_other_reg  <= s1_other_reg;
            s2_bad_reg    <= s1_bad_reg;
            s2_done_reg   <= s1_done_reg;
        end
        if (emit)
        begin
            out_glyph_reg <= e_glyph;
            out_last_reg  <= e_last;
            out_done_reg  <= e_last && s2_done_reg;
            out_bad_reg   <= !s2_hangul_reg && s2_bad_reg;
        end
    end

    assign glyphs.valid       = out_valid_reg;
    assign glyphs.glyph       = out_glyph_reg;
    assign glyphs.char_last   = out_last_reg;
    assign glyphs.string_done = out_done_reg;
    assign glyphs.bad_letter  = out_bad_reg;

endmodule

/* rtl/arabic_hangul_glyph_shaper.sv */
// Path: a released character passes the queue, s1, s2 and the output register; a
//   character is released when the next one arrives or at string end.
// Throughput: one glyph per cycle from the output register while glyphs.ready holds;
//   a Hangul syllable gives 2 or 3 glyphs, others 1; a string end that flushes a held
//   character stalls input while the single queue push port takes the second job.
// Reset: asynchronous, active low; clears the held character, queue and pipeline.
module arabic_hangul_glyph_shaper
    import ahgs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    ahgs_in_if.sink    chars,
    ahgs_out_if.source glyphs
);

    logic push;
    job_t push_job;
    logic full;
    logic pop;
    logic q_valid;
    job_t q_job;

    ahgs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .chars    (chars),
        .full     (full),
        .push     (push),
        .push_job (push_job)
    );

    ahgs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_job    (q_job)
    );

    ahgs_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_job   (q_job),
        .pop     (pop),
        .glyphs  (glyphs)
    );

`ifndef NO_ASSERTIONS
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("job pushed into a full queue");

    assert property (@(posedge clk) disable iff (!rst_n) pop |-> q_valid)
        else $error("job popped from an empty queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        (glyphs.valid && glyphs.string_done) |-> glyphs.char_last)
        else $error("string closed before its last character ended");

    assert property (@(posedge clk) disable iff (!rst_n)
        (glyphs.valid && glyphs.bad_letter) |-> glyphs.char_last)
        else $error("bad letter flagged inside a multi-glyph character");
`endif

endmodule
